// ===== hdl/smh_pkg.sv =====
// ----------------------------------------------------------------------------
// smh_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package smh_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 512;
   localparam int unsigned LEN_W   = 64;

   localparam logic [5:0] POS_LAST = 6'd63;
   localparam logic [5:0] POS_LEN  = 6'd56;
   localparam logic [5:0] RND_LAST = 6'd63;
   localparam logic [2:0] IDX_LAST = 3'd7;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   // initial hash value, H0 at index 0
   localparam logic [7:0][31:0] SMH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK,
      S_ZERO,
      S_ROUND,
      S_FOLD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic             shift_byte;
      logic [7:0]       byte_val;
      logic             load_len;
      logic [LEN_W-1:0] length;
      logic             start;
      logic             round;
      logic [5:0]       rnd;
      logic             fold;
      logic             init_chain;
   } ctrl_type;

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   // round constants
   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/smh_core.sv =====
// ----------------------------------------------------------------------------
// smh_core
// Block buffer / schedule window, working variables, chaining value and the
// single shared round unit.
// ----------------------------------------------------------------------------
module smh_core import smh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  logic [2:0]        out_idx,
   output logic [WORD_W-1:0] digest_word
);

   // buffer word j sits at bits [511-32j -: 32]; the same register is the
   // schedule window during the rounds (oldest word in the top slot)
   logic [BLOCK_W-1:0] blk_ff, blk_in;
   logic [7:0][31:0]   vars_ff, vars_in;
   logic [7:0][31:0]   chain_ff, chain_in;

   logic [31:0] w_0, w_1, w_9, w_14, w_sched, w_cur, t1, t2;

   assign w_0  = blk_ff[511:480];
   assign w_1  = blk_ff[479:448];
   assign w_9  = blk_ff[223:192];
   assign w_14 = blk_ff[63:32];

   always_comb begin
      w_sched = small_s1(w_14) + w_9 + small_s0(w_1) + w_0;
      w_cur   = (ctrl.rnd[5:4] == 2'b00) ? w_0 : w_sched;
      t1 = vars_ff[7] + big_s1(vars_ff[4]) + choose(vars_ff[4], vars_ff[5], vars_ff[6])
         + round_k(ctrl.rnd) + w_cur;
      t2 = big_s0(vars_ff[0]) + majority(vars_ff[0], vars_ff[1], vars_ff[2]);

      blk_in = blk_ff;
      if (ctrl.shift_byte) begin
         blk_in = {blk_ff[BLOCK_W-9:0], ctrl.byte_val};
      end else if (ctrl.load_len) begin
         blk_in = {blk_ff[BLOCK_W-LEN_W-1:0], ctrl.length};
      end else if (ctrl.round) begin
         blk_in = {blk_ff[BLOCK_W-WORD_W-1:0], w_cur};
      end

      vars_in = vars_ff;
      if (ctrl.start) begin
         vars_in = chain_ff;
      end else if (ctrl.round) begin
         vars_in[0] = t1 + t2;
         vars_in[1] = vars_ff[0];
         vars_in[2] = vars_ff[1];
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[5] = vars_ff[4];
         vars_in[6] = vars_ff[5];
         vars_in[7] = vars_ff[6];
      end

      chain_in = chain_ff;
      if (ctrl.init_chain) begin
         chain_in = SMH_IV;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      vars_ff <= vars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SMH_IV;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign digest_word = chain_ff[out_idx];

endmodule

// ===== hdl/smh_ctrl.sv =====
// ----------------------------------------------------------------------------
// smh_ctrl
// Sequencer: byte intake, padding, round count and digest readout.
// ----------------------------------------------------------------------------
module smh_ctrl import smh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_has_byte,
   input  logic       in_end,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [2:0] out_idx,
   output logic       out_last,
   output ctrl_type   ctrl
);

   state_type        state_ff, state_in;
   state_type        resume_ff, resume_in;   // where to go after the fold
   logic [5:0]       pos_ff, pos_in;         // byte slot in the block
   logic [LEN_W-1:0] bits_ff, bits_in;
   logic [5:0]       rnd_ff, rnd_in;
   logic [2:0]       oidx_ff, oidx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resume_ff <= S_IDLE;
         pos_ff    <= '0;
         bits_ff   <= '0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         pos_ff    <= pos_in;
         bits_ff   <= bits_in;
         rnd_ff    <= rnd_in;
         oidx_ff   <= oidx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      pos_in    = pos_ff;
      bits_in   = bits_ff;
      rnd_in    = rnd_ff;
      oidx_in   = oidx_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      ctrl      = '0;
      ctrl.length = bits_ff;
      ctrl.rnd    = rnd_ff;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_has_byte) begin
                  ctrl.shift_byte = 1'b1;
                  ctrl.byte_val   = in_byte;
                  pos_in  = pos_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               if (in_has_byte && pos_ff == POS_LAST) begin
                  ctrl.start = 1'b1;
                  resume_in  = in_end ? S_MARK : S_IDLE;
                  state_in   = S_ROUND;
               end else if (in_end) begin
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = PAD_MARK;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               ctrl.start = 1'b1;
               resume_in  = S_ZERO;
               state_in   = S_ROUND;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO: begin
            if (pos_ff == POS_LEN) begin
               ctrl.load_len = 1'b1;
               ctrl.start    = 1'b1;
               pos_in    = '0;
               resume_in = S_OUT;
               state_in  = S_ROUND;
            end else begin
               ctrl.shift_byte = 1'b1;
               ctrl.byte_val   = PAD_ZERO;
               pos_in = pos_ff + 6'd1;
               if (pos_ff == POS_LAST) begin
                  ctrl.start = 1'b1;
                  resume_in  = S_ZERO;
                  state_in   = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            ctrl.round = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == RND_LAST) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            ctrl.fold = 1'b1;
            state_in  = resume_ff;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == IDX_LAST) begin
                  ctrl.init_chain = 1'b1;
                  bits_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_idx  = oidx_ff;
   assign out_last = (oidx_ff == IDX_LAST);

endmodule

// ===== hdl/sha256_message_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// Byte-serial SHA-256 hasher with one shared round unit.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser    | tlast
//  req     | in  | [7:0] data_byte               | has_byte | end_of_message
//  rsp     | out | [31:0] digest_word,           | -        | last_word
//          |     | [34:32] word_index, [39:35] 0 |          |
//
//  Each message byte is taken while the unit is idle; every 64th byte starts
//  a compression (64 rounds on the single round unit, then a fold into the
//  chaining value), during which no further byte is taken.
//  End of message: pad bytes up to slot 56, the length, one or two
//  compressions, then 8 digest words.
//  Synchronous reset returns the chaining value to the initial hash and
//  clears the byte and bit counts.
//  req_tready is low while a block is compressed, padded or read out;
//  rsp_tready low holds the current digest word.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit import smh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   // digest words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
   output logic        rsp_tlast    // last_word
);

   ctrl_type          ctrl;
   logic [2:0]        out_idx;
   logic [WORD_W-1:0] digest_word;

   // sequencer: intake, padding, round count, readout
   smh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_has_byte (req_tuser[0]),
      .in_end      (req_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_idx     (out_idx),
      .out_last    (rsp_tlast),
      .ctrl        (ctrl)
   );

   // datapath: buffer/window, working vars, chaining value, round unit
   smh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .out_idx     (out_idx),
      .digest_word (digest_word)
   );

   assign rsp_tdata = {5'b0, out_idx, digest_word};

endmodule

// ===== hdl/smh_checker.sv =====
// ----------------------------------------------------------------------------
// smh_checker
// Port-level checks of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module smh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // no intake while the digest is read out
   a_no_intake_on_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during digest readout");

   // last mark only on word 7
   a_last_on_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last_word does not match word_index");

   // words follow one another without a gap in the index
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("digest word index skipped");

   // an end word always starts padding, or first a compression and then padding
   a_end_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("still ready right after end of message");

   // after the last word the block is ready for the next message
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not ready after the last digest word");

endmodule

bind sha256_message_hasher_unit smh_checker u_smh_checker (.*);
